FILE: rtl/core/wildcard_byte_pattern_scanner_macros.svh
// assertion macros shared by the scanner checker
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_MACROS_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_MACROS_SVH

// same-cycle implication on the scanner clock
`define WBPS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("scanner check failed");

// next-cycle implication on the scanner clock
`define WBPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("scanner check failed");

`endif

FILE: rtl/core/wbps_pkg.sv
// shared types, constants and helper functions of the byte pattern scanner
package wbps_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W       = $clog2(MAX_PATTERN);
    localparam int ADDR_W      = 32;
    localparam int PAT_W       = 64;
    localparam int DATA_W      = 64;
    localparam int PADDR_W     = 6;
    localparam int REG_IDX_W   = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PATTERN_LOW  = 3'd0,
        REG_PATTERN_HIGH = 3'd1,
        REG_WILDCARD     = 3'd2,
        REG_LENGTH       = 3'd3,
        REG_BASE         = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [PAT_W-1:0]       pattern_low;
        logic [PAT_W-1:0]       pattern_high;
        logic [MAX_PATTERN-1:0] wildcard_mask;
        logic [LEN_W-1:0]       pattern_length;
        logic [ADDR_W-1:0]      base_address;
    } cfg_t;

    function automatic logic [LEN_W-1:0] eff_length(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] res;
        res = len;
        if (len == '0) begin
            res = LEN_W'(1);
        end else if (len > LEN_W'(MAX_PATTERN)) begin
            res = LEN_W'(MAX_PATTERN);
        end
        return res;
    endfunction

    function automatic logic [7:0] pattern_byte(input cfg_t c, input logic [IDX_W-1:0] k);
        logic [7:0] res;
        if (k[3]) begin
            res = c.pattern_high[{k[2:0], 3'b000} +: 8];
        end else begin
            res = c.pattern_low[{k[2:0], 3'b000} +: 8];
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/wildcard_byte_pattern_scanner.sv
// top level of the wildcard byte pattern scanner
//
// usage:
// - the s_ channel carries the scanned region one byte per beat, in address
//   order, with s_last_byte on the final byte
// - the m_ channel carries at most one result beat per region: m_found=1 and
//   the match start address at the first match, or m_found=0 and address 0
//   on the last byte when nothing matched
// - pattern, wildcard mask, length and base address sit in apb registers at
//   byte addresses 0, 8, 16, 24 and 32; write them while no result is pending
// - one byte is taken every cycle while s_ready is high; a row of 16 window
//   cells shifts the bytes and compares all pattern positions in the same cycle
// - the result beat shows on m_valid in the cycle after the byte that
//   completes the match (or the last byte) is accepted
// - a single output register holds the result; while it is full and m_ready
//   is low, s_ready is low and the window holds
// - reset clears the window, the byte count, the match flag and the output
//   valid flag, and loads the register reset values (length 1, others 0)
module wildcard_byte_pattern_scanner (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wbps_pkg::PADDR_W-1:0]  paddr,
    input  logic [wbps_pkg::DATA_W-1:0]   pwdata,
    output logic [wbps_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_data_byte,
    input  logic                          s_last_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_found,
    output logic [wbps_pkg::ADDR_W-1:0]   m_match_address
);

    localparam int N = wbps_pkg::MAX_PATTERN;

    wbps_pkg::cfg_t               cfg;
    logic [wbps_pkg::LEN_W-1:0]   len_eff;
    logic [7:0]                   chain [N+1];
    logic [N-1:0]                 cell_hit;
    logic                         accept;
    logic                         hit;
    logic                         emit;

    logic [wbps_pkg::ADDR_W-1:0]  seen_reg;
    logic [wbps_pkg::ADDR_W-1:0]  seen_next;
    logic [wbps_pkg::ADDR_W-1:0]  seen_inc;
    logic                         matched_reg;
    logic                         matched_next;
    logic                         m_valid_reg;
    logic                         m_valid_next;
    logic                         m_found_reg;
    logic                         m_found_next;
    logic [wbps_pkg::ADDR_W-1:0]  m_addr_reg;
    logic [wbps_pkg::ADDR_W-1:0]  m_addr_next;

    wbps_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign len_eff = wbps_pkg::eff_length(cfg.pattern_length);
    assign s_ready = ~m_valid_reg | m_ready;
    assign accept  = s_valid & s_ready;
    assign chain[0] = s_data_byte;

    // cell i holds window position i and checks pattern byte len-1-i
    for (genvar i = 0; i < N; i++) begin : g_cell
        localparam logic [wbps_pkg::LEN_W-1:0] POS = wbps_pkg::LEN_W'(i);
        logic [wbps_pkg::LEN_W-1:0] k;
        logic                       in_use;

        assign k      = len_eff - POS - wbps_pkg::LEN_W'(1);
        assign in_use = POS < len_eff;

        wbps_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (accept),
            .clear    (s_last_byte),
            .d_in     (chain[i]),
            .pat_byte (wbps_pkg::pattern_byte(cfg, k[wbps_pkg::IDX_W-1:0])),
            .pat_wild (cfg.wildcard_mask[k[wbps_pkg::IDX_W-1:0]]),
            .in_use   (in_use),
            .d_out    (chain[i+1]),
            .hit      (cell_hit[i])
        );
    end

    // saturating byte count after this beat
    assign seen_inc = (seen_reg == '1) ? seen_reg : seen_reg + wbps_pkg::ADDR_W'(1);

    assign hit  = ~matched_reg & (seen_inc >= wbps_pkg::ADDR_W'(len_eff)) & (&cell_hit);
    assign emit = hit | (s_last_byte & ~matched_reg);

    always_comb begin
        seen_next    = seen_reg;
        matched_next = matched_reg;
        m_valid_next = m_valid_reg;
        m_found_next = m_found_reg;
        m_addr_next  = m_addr_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            if (s_last_byte) begin
                seen_next    = '0;
                matched_next = 1'b0;
            end else begin
                seen_next    = seen_inc;
                matched_next = matched_reg | hit;
            end
            if (emit) begin
                m_valid_next = 1'b1;
                m_found_next = hit;
                m_addr_next  = hit ? cfg.base_address + seen_inc
                                     - wbps_pkg::ADDR_W'(len_eff) : '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg    <= '0;
            matched_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            seen_reg    <= seen_next;
            matched_reg <= matched_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_found_reg <= m_found_next;
        m_addr_reg  <= m_addr_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_found         = m_found_reg;
    assign m_match_address = m_addr_reg;

endmodule

FILE: rtl/core/wbps_regs.sv
// apb configuration registers of the byte pattern scanner
module wbps_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wbps_pkg::PADDR_W-1:0]  paddr,
    input  logic [wbps_pkg::DATA_W-1:0]   pwdata,
    output logic [wbps_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output wbps_pkg::cfg_t                cfg
);

    wbps_pkg::cfg_t     cfg_reg;
    wbps_pkg::cfg_t     cfg_next;
    wbps_pkg::reg_idx_t idx;
    logic               wr_en;

    assign idx    = wbps_pkg::reg_idx_t'(paddr[wbps_pkg::PADDR_W-1:3]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                wbps_pkg::REG_PATTERN_LOW:  cfg_next.pattern_low = pwdata;
                wbps_pkg::REG_PATTERN_HIGH: cfg_next.pattern_high = pwdata;
                wbps_pkg::REG_WILDCARD:
                    cfg_next.wildcard_mask = pwdata[wbps_pkg::MAX_PATTERN-1:0];
                wbps_pkg::REG_LENGTH:
                    cfg_next.pattern_length = pwdata[wbps_pkg::LEN_W-1:0];
                wbps_pkg::REG_BASE:
                    cfg_next.base_address = pwdata[wbps_pkg::ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (idx)
            wbps_pkg::REG_PATTERN_LOW:  prdata = cfg_reg.pattern_low;
            wbps_pkg::REG_PATTERN_HIGH: prdata = cfg_reg.pattern_high;
            wbps_pkg::REG_WILDCARD:
                prdata = wbps_pkg::DATA_W'(cfg_reg.wildcard_mask);
            wbps_pkg::REG_LENGTH:
                prdata = wbps_pkg::DATA_W'(cfg_reg.pattern_length);
            wbps_pkg::REG_BASE:
                prdata = wbps_pkg::DATA_W'(cfg_reg.base_address);
            default: prdata = '0;
        endcase
    end

    // reset values: length 1, everything else 0
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= {{(2 * wbps_pkg::PAT_W + wbps_pkg::MAX_PATTERN){1'b0}},
                        wbps_pkg::LEN_W'(1), {wbps_pkg::ADDR_W{1'b0}}};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/core/wbps_cell.sv
// one window cell: holds a byte, passes it on, compares the incoming byte
module wbps_cell (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       shift_en,
    input  logic       clear,
    input  logic [7:0] d_in,
    input  logic [7:0] pat_byte,
    input  logic       pat_wild,
    input  logic       in_use,
    output logic [7:0] d_out,
    output logic       hit
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    // compare against the byte this cell holds after the shift
    assign hit   = ~in_use | pat_wild | (d_in == pat_byte);
    assign d_out = byte_reg;

    always_comb begin
        byte_next = byte_reg;
        if (shift_en) begin
            byte_next = clear ? 8'h00 : d_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg <= 8'h00;
        end else begin
            byte_reg <= byte_next;
        end
    end

endmodule

FILE: rtl/core/wbps_checker.sv
// port-level checker of the byte pattern scanner, bound to the top level
`include "wildcard_byte_pattern_scanner_macros.svh"

module wbps_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic                          m_found,
    input logic [wbps_pkg::ADDR_W-1:0]   m_match_address
);

    // a not-found beat carries a zero address
    `WBPS_ASSERT_SAME(a_notfound_zero, m_valid && !m_found, m_match_address == '0)

    // an empty output register never blocks the input
    `WBPS_ASSERT_SAME(a_ready_when_empty, !m_valid, s_ready)

    // a stalled result beat holds
    `WBPS_ASSERT_NEXT(a_result_holds, m_valid && !m_ready,
        m_valid && $stable(m_found) && $stable(m_match_address))

    // with the output full and stalled, no input beat is taken
    `WBPS_ASSERT_SAME(a_no_take_when_full, m_valid && !m_ready, !(s_valid && s_ready))

endmodule

bind wildcard_byte_pattern_scanner wbps_checker u_wbps_checker (.*);
